/* design/icpf_pkg.sv */
`default_nettype none
package icpf_pkg;
   localparam int BloomLog2 = 20;
   localparam int FrameLen = 110;
   localparam logic [31:0] SeedCheck = 32'h11112222;
   localparam logic [31:0] SeedBloomA = 32'h12345678;
   localparam logic [31:0] SeedBloomB = 32'h87654321;

   typedef logic [BloomLog2-1:0] bloom_addr_type;

   // one-hot states of the filter FSM
   typedef enum logic [7:0] {
      ST_RECV   = 8'b0000_0001,
      ST_FIN0   = 8'b0000_0010,
      ST_FIN1   = 8'b0000_0100,
      ST_FIN2   = 8'b0000_1000,
      ST_FIN3   = 8'b0001_0000,
      ST_READ   = 8'b0010_0000,
      ST_WRITE  = 8'b0100_0000,
      ST_CLEAR  = 8'b1000_0000
   } state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
      rotl = (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] w);
      bswap = {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction
endpackage
`default_nettype wire

/* design/icmpv6_unreachable_probe_filter_unit.sv */
`default_nettype none
// channel | dir | tdata fields (low bit up)                    | tlast
// req     | in  | packet_byte[7:0]                             | last_byte
// rsp     | out | accepted, target_high, target_low,           | -
//         |     | seq_prefix, zero pad (160 bits)               |
// bytes are taken one per cycle while a frame is being received; the three
// hashes mix one 32-bit block per mix step in a three-stage multiply chain.
// after the last byte the block drains the mix chain, runs two finish steps,
// the tag compare, the bloom read and the bloom write before the next request;
// the response goes valid with the bloom write.
// after reset a clearing pass sweeps all 2^20 bloom memory entries; no
// request is taken meanwhile. a waiting response stalls the next frame end.
module icmpv6_unreachable_probe_filter_unit
   import icpf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // packet_byte
   input  wire logic         req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata    // accepted, target_high, target_low, seq_prefix
);
   state_type state_ff, state_in;
   logic [6:0] off_ff, off_in;
   logic hok_ff, hok_in;
   logic [63:0] qa0_ff, qa0_in, qa1_ff, qa1_in;
   logic [31:0] qs_ff, qs_in;
   logic [31:0] h0_ff, h0_in, h1_ff, h1_in, h2_ff, h2_in;
   // mix pipeline: stage a = k*c1, stage b = rot*c2, stage c = apply
   logic        mv_a_ff, mv_b_ff;
   logic        mchk_a_ff, mchk_b_ff;
   logic [31:0] mk_a_ff, mk_b_ff;
   logic [31:0] f0_ff, f0_in, f1_ff, f1_in, f2_ff, f2_in;
   bloom_addr_type clr_ff, clr_in;
   logic        ok_ff, ok_in;
   logic        rv_ff, rv_in;
   logic [159:0] rd_ff, rd_in;
   logic        bloom_mem [0:(1<<BloomLog2)-1];
   logic        ra_ff, rb_ff;
   logic        bwe;
   bloom_addr_type bwa;
   logic        bwd;
   logic        acc;
   logic        mix_now;
   logic [31:0] kword;

   assign acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_RECV);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign kword = bswap(off_ff <= 7'd93 ? qa0_in[31:0] : qa1_in[31:0]);
   assign mix_now = acc && (off_ff == 7'd89 || off_ff == 7'd93 ||
                            off_ff == 7'd97 || off_ff == 7'd101);

   // bloom memory, one write and two reads, sweep at reset
   always_ff @(posedge clock) begin
      if (bwe) bloom_mem[bwa] <= bwd;
      ra_ff <= bloom_mem[f1_ff[BloomLog2-1:0]];
      rb_ff <= bloom_mem[f2_ff[BloomLog2-1:0]];
   end

   // mix pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_a_ff <= 1'b0;
         mv_b_ff <= 1'b0;
      end else begin
         mv_a_ff <= mix_now;
         mv_b_ff <= mv_a_ff;
      end
      mchk_a_ff <= (off_ff != 7'd101);
      mchk_b_ff <= mchk_a_ff;
      mk_a_ff <= kword * 32'hcc9e2d51;
      mk_b_ff <= rotl(mk_a_ff, 15) * 32'h1b873593;
   end

   always_comb begin
      logic [31:0] t;
      state_in = state_ff;
      off_in = off_ff; hok_in = hok_ff;
      qa0_in = qa0_ff; qa1_in = qa1_ff; qs_in = qs_ff;
      h0_in = h0_ff; h1_in = h1_ff; h2_in = h2_ff;
      f0_in = f0_ff; f1_in = f1_ff; f2_in = f2_ff;
      clr_in = clr_ff; ok_in = ok_ff;
      rv_in = rv_ff && !rsp_tready; rd_in = rd_ff;
      bwe = 1'b0; bwa = clr_ff; bwd = 1'b0;
      t = 32'd0;
      // byte capture
      if (acc && off_ff < 7'(FrameLen)) begin
         if ((off_ff == 7'd12 && req_tdata != 8'h86) ||
             (off_ff == 7'd13 && req_tdata != 8'hDD) ||
             (off_ff == 7'd20 && req_tdata != 8'd58) ||
             (off_ff == 7'd54 && req_tdata != 8'd1) ||
             (off_ff == 7'd55 && req_tdata != 8'd0))
            hok_in = 1'b0;
         if (off_ff >= 7'd86 && off_ff <= 7'd93) qa0_in = {qa0_ff[55:0], req_tdata};
         if (off_ff >= 7'd94 && off_ff <= 7'd101) qa1_in = {qa1_ff[55:0], req_tdata};
         if (off_ff >= 7'd106 && off_ff <= 7'd109) qs_in = {qs_ff[23:0], req_tdata};
         off_in = off_ff + 7'd1;
      end
      // last mix stage
      if (mv_b_ff) begin
         if (mchk_b_ff) h0_in = rotl(h0_ff ^ mk_b_ff, 13) * 32'd5 + 32'he6546b64;
         h1_in = rotl(h1_ff ^ mk_b_ff, 13) * 32'd5 + 32'he6546b64;
         h2_in = rotl(h2_ff ^ mk_b_ff, 13) * 32'd5 + 32'he6546b64;
      end
      case (state_ff)
         ST_CLEAR: begin
            bwe = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = ST_RECV;
         end
         ST_RECV: begin
            if (acc && req_tlast) state_in = ST_FIN0;
         end
         ST_FIN0: begin
            // wait for mix pipe to drain, then xor length and fold
            if (!mv_a_ff && !mv_b_ff) begin
               t = h0_ff ^ 32'd12; f0_in = t ^ (t >> 16);
               t = h1_ff ^ 32'd16; f1_in = t ^ (t >> 16);
               t = h2_ff ^ 32'd16; f2_in = t ^ (t >> 16);
               state_in = ST_FIN1;
            end
         end
         ST_FIN1: begin
            t = f0_ff * 32'h85ebca6b; f0_in = t ^ (t >> 13);
            t = f1_ff * 32'h85ebca6b; f1_in = t ^ (t >> 13);
            t = f2_ff * 32'h85ebca6b; f2_in = t ^ (t >> 13);
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            t = f0_ff * 32'hc2b2ae35; f0_in = t ^ (t >> 16);
            t = f1_ff * 32'hc2b2ae35; f1_in = t ^ (t >> 16);
            t = f2_ff * 32'hc2b2ae35; f2_in = t ^ (t >> 16);
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            ok_in = hok_ff && (off_ff >= 7'(FrameLen)) && (qa1_ff[31:0] == f0_ff);
            state_in = ST_READ;
         end
         ST_READ: begin
            // read data ra_ff/rb_ff now valid
            if (ok_ff && ra_ff && rb_ff) ok_in = 1'b0;
            if (ok_ff && !(ra_ff && rb_ff)) begin
               bwe = 1'b1; bwa = f1_ff[BloomLog2-1:0]; bwd = 1'b1;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rv_ff || rsp_tready) begin
               if (ok_ff) begin
                  bwe = 1'b1; bwa = f2_ff[BloomLog2-1:0]; bwd = 1'b1;
               end
               rv_in = 1'b1;
               rd_in = ok_ff ? {7'd0, qs_ff[31:8], qa1_ff, qa0_ff, 1'b1}
                             : 160'd0;
               off_in = 7'd0; hok_in = 1'b1;
               qa0_in = 64'd0; qa1_in = 64'd0; qs_in = 32'd0;
               h0_in = SeedCheck; h1_in = SeedBloomA; h2_in = SeedBloomB;
               state_in = ST_RECV;
            end
         end
         default: state_in = ST_RECV;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         off_ff <= 7'd0; hok_ff <= 1'b1;
         qa0_ff <= 64'd0; qa1_ff <= 64'd0; qs_ff <= 32'd0;
         h0_ff <= SeedCheck; h1_ff <= SeedBloomA; h2_ff <= SeedBloomB;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         off_ff <= off_in; hok_ff <= hok_in;
         qa0_ff <= qa0_in; qa1_ff <= qa1_in; qs_ff <= qs_in;
         h0_ff <= h0_in; h1_ff <= h1_in; h2_ff <= h2_in;
      end
      f0_ff <= f0_in; f1_ff <= f1_in; f2_ff <= f2_in;
      ok_ff <= ok_in;
      rd_ff <= rd_in;
   end
endmodule
`default_nettype wire
